FILE: rtl/lfcg_pkg.sv
// ----------------------------------------------------------------------------
// lfcg_pkg: shared types and constants for the log fade compare generator
// Beat structs, configuration codes and the fixed logarithmic curve table.
// ----------------------------------------------------------------------------
package lfcg_pkg;

  localparam int StepW   = 8;
  localparam int CmpW    = 15;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 8;
  localparam int RomIdxW = 6;

  localparam logic [RomIdxW-1:0] RomLast = 6'd63;

  localparam logic [StepW-1:0] TicksPerStepRst = 8'd1;
  localparam logic [StepW-1:0] LastStepRst     = 8'd250;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_STEP = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LAST_STEP      = 2'd1;

  // interpolation fraction codes
  localparam logic [1:0] FRAC_ZERO    = 2'd0;
  localparam logic [1:0] FRAC_QUARTER = 2'd1;
  localparam logic [1:0] FRAC_HALF    = 2'd2;

  typedef struct packed {
    logic func;          // 0 period tick, 1 switch sample
    logic switch_level;
  } in_item_t;

  typedef struct packed {
    logic [CmpW-1:0] compare_value;
    logic            updated;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    logic     fire;
    in_item_t item;
  } step_req_t;

  // decreasing log curve, entry 0 = full scale
  function automatic logic [CmpW-1:0] log_rom(input logic [RomIdxW-1:0] i);
    logic [CmpW-1:0] v;
    case (i)
      6'd0:  v = 15'd16384; 6'd1:  v = 15'd13653; 6'd2:  v = 15'd12056;
      6'd3:  v = 15'd10923; 6'd4:  v = 15'd10044; 6'd5:  v = 15'd9325;
      6'd6:  v = 15'd8718;  6'd7:  v = 15'd8192;  6'd8:  v = 15'd7728;
      6'd9:  v = 15'd7313;  6'd10: v = 15'd6937;  6'd11: v = 15'd6595;
      6'd12: v = 15'd6279;  6'd13: v = 15'd5987;  6'd14: v = 15'd5716;
      6'd15: v = 15'd5461;  6'd16: v = 15'd5223;  6'd17: v = 15'd4997;
      6'd18: v = 15'd4784;  6'd19: v = 15'd4582;  6'd20: v = 15'd4390;
      6'd21: v = 15'd4207;  6'd22: v = 15'd4032;  6'd23: v = 15'd3864;
      6'd24: v = 15'd3703;  6'd25: v = 15'd3549;  6'd26: v = 15'd3400;
      6'd27: v = 15'd3257;  6'd28: v = 15'd3118;  6'd29: v = 15'd2985;
      6'd30: v = 15'd2856;  6'd31: v = 15'd2731;  6'd32: v = 15'd2609;
      6'd33: v = 15'd2492;  6'd34: v = 15'd2378;  6'd35: v = 15'd2267;
      6'd36: v = 15'd2159;  6'd37: v = 15'd2054;  6'd38: v = 15'd1951;
      6'd39: v = 15'd1852;  6'd40: v = 15'd1754;  6'd41: v = 15'd1659;
      6'd42: v = 15'd1567;  6'd43: v = 15'd1476;  6'd44: v = 15'd1388;
      6'd45: v = 15'd1301;  6'd46: v = 15'd1216;  6'd47: v = 15'd1133;
      6'd48: v = 15'd1052;  6'd49: v = 15'd973;   6'd50: v = 15'd894;
      6'd51: v = 15'd818;   6'd52: v = 15'd743;   6'd53: v = 15'd669;
      6'd54: v = 15'd597;   6'd55: v = 15'd526;   6'd56: v = 15'd456;
      6'd57: v = 15'd388;   6'd58: v = 15'd320;   6'd59: v = 15'd254;
      6'd60: v = 15'd189;   6'd61: v = 15'd125;   6'd62: v = 15'd62;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/lfcg_curve.sv
// ----------------------------------------------------------------------------
// lfcg_curve: log curve lookup with quarter-step interpolation
// Upper step bits pick a table entry, low two bits blend toward the next one.
// ----------------------------------------------------------------------------
module lfcg_curve import lfcg_pkg::*; (
  input  logic [StepW-1:0] step,
  output logic [CmpW-1:0]  value
);

  logic [RomIdxW-1:0] idx;
  logic [RomIdxW-1:0] idx_next;
  logic [CmpW-1:0]    a;
  logic [CmpW-1:0]    b;
  logic [CmpW-1:0]    a_q;
  logic [CmpW-1:0]    b_q;
  logic [CmpW-1:0]    a_h;
  logic [CmpW-1:0]    b_h;

  assign idx      = step[StepW-1:2];
  // last entry has no successor: hold it
  assign idx_next = (idx == RomLast) ? RomLast : idx + 1'b1;
  assign a        = log_rom(idx);
  assign b        = log_rom(idx_next);
  assign a_q      = a >> 2;
  assign b_q      = b >> 2;
  assign a_h      = a >> 1;
  assign b_h      = b >> 1;

  always_comb begin
    case (step[1:0])
      FRAC_ZERO:    value = a;
      FRAC_QUARTER: value = a_q + a_q + a_q + b_q;
      FRAC_HALF:    value = a_h + b_h;
      default:      value = a_q + b_q + b_q + b_q;
    endcase
  end

endmodule

FILE: rtl/lfcg_core.sv
// ----------------------------------------------------------------------------
// lfcg_core: fade state and configuration registers
// Prescaler, fade step and held compare value; one beat per cycle.
// ----------------------------------------------------------------------------
module lfcg_core import lfcg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg,
  input  step_req_t req,
  output out_item_t result
);

  logic [StepW-1:0] tps_r,  tps_nxt;
  logic [StepW-1:0] last_r, last_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [StepW-1:0] cnt_r,  cnt_nxt;
  logic [CmpW-1:0]  cmp_r,  cmp_nxt;
  logic [StepW-1:0] cnt_dec;
  logic [CmpW-1:0]  curve;
  logic             tick;
  logic             running;
  logic             advance;

  lfcg_curve u_curve (
    .step  (step_r),
    .value (curve)
  );

  assign tick    = req.fire && !req.item.func;
  assign running = step_r < last_r;
  assign cnt_dec = cnt_r - 1'b1;   // zero wraps to 255
  assign advance = tick && running && (cnt_dec == '0);

  always_comb begin
    tps_nxt  = tps_r;
    last_nxt = last_r;
    if (cfg.valid) begin
      case (cfg.idx)
        CFG_TICKS_PER_STEP: tps_nxt  = cfg.data;
        CFG_LAST_STEP:      last_nxt = cfg.data;
        default:            ;
      endcase
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    step_nxt = step_r;
    cmp_nxt  = cmp_r;
    if (req.fire && req.item.func) begin
      if (!req.item.switch_level) begin
        step_nxt = '0;
      end
    end else if (tick && running) begin
      cnt_nxt = cnt_dec;
      if (advance) begin
        cnt_nxt  = tps_r;
        cmp_nxt  = curve;
        step_nxt = step_r + 1'b1;
      end
    end
  end

  assign result.compare_value = cmp_nxt;
  assign result.updated       = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r  <= TicksPerStepRst;
      last_r <= LastStepRst;
      step_r <= '0;
      cnt_r  <= TicksPerStepRst;
      cmp_r  <= '0;
    end else begin
      tps_r  <= tps_nxt;
      last_r <= last_nxt;
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
      cmp_r  <= cmp_nxt;
    end
  end

`ifndef SYNTHESIS
  a_adv_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> step_r == $past(step_r) + 1'b1)
    else $error("fade step did not advance on update");

  a_adv_reload: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> cnt_r == $past(tps_r))
    else $error("prescaler not reloaded on update");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (req.fire && req.item.func && !req.item.switch_level) |=> step_r == '0)
    else $error("low switch sample did not restart fade");
`endif

endmodule

FILE: rtl/log_fade_compare_generator_top.sv
// ----------------------------------------------------------------------------
// log_fade_compare_generator_top: LED log fade ramp for a PWM compare register
// Input register, fade state update and result register.
// ----------------------------------------------------------------------------
// A beat in the input register moves through the core to the result register.
// Throughput: one beat per cycle while out_stall is low, set by the single
//   input-to-result pass; an empty input register takes a beat while a result waits.
// Reset (rst_n low, synchronous): ticks_per_step = 1, last_step = 250,
//   fade step 0, prescaler 1, compare value 0, both channels empty.
// Config writes always complete (cfg_ready is tied high).
module log_fade_compare_generator_top import lfcg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      in_fire;
  logic      s1_adv;     // input register hands its beat to the core
  step_req_t req;
  cfg_wr_t   cfg;
  out_item_t result;

  // result register is free when empty or being drained this cycle
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.idx   = cfg_index;
  assign cfg.data  = cfg_data;

  assign req.fire = s1_adv;
  assign req.item = s1_item_r;

  lfcg_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .req    (req),
    .result (result)
  );

  always_comb begin
    s1_valid_nxt = in_fire || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
